// ===== hw/rtl/nkps_pkg.sv =====
// Shared types and constants of the nearest-k point selector.
// Depends on nothing; every other file of the block imports it.
package nkps_pkg;

  localparam int COORD_W      = 16;
  localparam int ID_W         = 16;
  localparam int MAG_W        = 16;
  localparam int SQ_W         = 32;
  localparam int DIST_W       = 34;
  localparam int SLOT_W       = 3;
  localparam int SLOT_MAX     = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int KEEP_DEF     = 8;

  // Configuration register indexes; index 3 is not decoded
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_X = 2'd0,
    REG_REF_Y = 2'd1,
    REG_REF_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } ref_pt_t;

  // Candidate leaving the distance pipeline
  typedef struct packed {
    logic              vld;
    logic              fin;
    logic [DIST_W-1:0] sq_dist;
    logic [ID_W-1:0]   id;
  } cand_t;

  // One kept entry as held in a cell
  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] sq_dist;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic drn;
  } cell_ctrl_t;

  localparam entry_t ENTRY_EMPTY = '{vld: 1'b0, sq_dist: '0, id: '0};

endpackage

// ===== hw/rtl/nkps_dist.sv =====
// Three-stage squared-distance pipeline: difference magnitudes, squares, sum.
// Depends on nkps_pkg.
module nkps_dist (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic [nkps_pkg::ID_W-1:0]        point_id,
  input  logic signed [nkps_pkg::COORD_W-1:0] point_x,
  input  logic signed [nkps_pkg::COORD_W-1:0] point_y,
  input  logic signed [nkps_pkg::COORD_W-1:0] point_z,
  input  logic                             final_point,
  input  nkps_pkg::ref_pt_t                ref_pt,
  output nkps_pkg::cand_t                  cand,
  output logic                             fin_pending
);
  import nkps_pkg::*;

  logic                 s1_vld_r, s1_fin_r, s2_vld_r, s2_fin_r, s3_vld_r, s3_fin_r;
  logic [ID_W-1:0]      s1_id_r, s2_id_r, s3_id_r;
  logic [MAG_W-1:0]     s1_mx_r, s1_my_r, s1_mz_r;
  logic [SQ_W-1:0]      s2_qx_r, s2_qy_r, s2_qz_r;
  logic [DIST_W-1:0]    s3_dist_r;
  logic [MAG_W-1:0]     mx_nxt, my_nxt, mz_nxt;

  // Magnitude of a signed difference, at most 65535
  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = ~d + 1'b1;
    return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  assign mx_nxt = abs_diff(point_x, ref_pt.x);
  assign my_nxt = abs_diff(point_y, ref_pt.y);
  assign mz_nxt = abs_diff(point_z, ref_pt.z);

  // Advance the valid and final flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s1_fin_r <= 1'b0;
      s2_fin_r <= 1'b0;
      s3_fin_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s1_fin_r <= acc & final_point;
      s2_fin_r <= s1_fin_r;
      s3_fin_r <= s2_fin_r;
    end
  end

  // Carry the payload: magnitudes, then squares, then the sum
  always_ff @(posedge clk) begin
    s1_id_r   <= point_id;
    s1_mx_r   <= mx_nxt;
    s1_my_r   <= my_nxt;
    s1_mz_r   <= mz_nxt;
    s2_id_r   <= s1_id_r;
    s2_qx_r   <= SQ_W'(s1_mx_r) * SQ_W'(s1_mx_r);
    s2_qy_r   <= SQ_W'(s1_my_r) * SQ_W'(s1_my_r);
    s2_qz_r   <= SQ_W'(s1_mz_r) * SQ_W'(s1_mz_r);
    s3_id_r   <= s2_id_r;
    s3_dist_r <= DIST_W'(s2_qx_r) + DIST_W'(s2_qy_r) + DIST_W'(s2_qz_r);
  end

  assign cand.vld     = s3_vld_r;
  assign cand.fin     = s3_fin_r;
  assign cand.sq_dist = s3_dist_r;
  assign cand.id      = s3_id_r;
  assign fin_pending  = s1_fin_r | s2_fin_r | s3_fin_r;

endmodule

// ===== hw/rtl/nkps_cell.sv =====
// One cell of the sorted insertion chain: holds a single kept entry.
// Depends on nkps_pkg.
module nkps_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nkps_pkg::cell_ctrl_t       ctrl,
  input  logic [nkps_pkg::DIST_W-1:0] cand_dist,
  input  logic [nkps_pkg::ID_W-1:0]  cand_id,
  input  nkps_pkg::entry_t           prev_ent,
  input  logic                       prev_keep,
  input  nkps_pkg::entry_t           next_ent,
  output nkps_pkg::entry_t           ent,
  output logic                       keep
);
  import nkps_pkg::*;

  logic              vld_r, vld_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  // Hold when the candidate ranks at or after this entry (ties go behind)
  assign keep = vld_r && (cand_dist >= dist_r);

  always_comb begin
    vld_nxt  = vld_r;
    dist_nxt = dist_r;
    id_nxt   = id_r;
    priority if (ctrl.drn) begin
      // shift towards the head for readout
      vld_nxt  = next_ent.vld;
      dist_nxt = next_ent.sq_dist;
      id_nxt   = next_ent.id;
    end else if (ctrl.ins && !keep) begin
      if (prev_keep) begin
        vld_nxt  = 1'b1;
        dist_nxt = cand_dist;
        id_nxt   = cand_id;
      end else begin
        vld_nxt  = prev_ent.vld;
        dist_nxt = prev_ent.sq_dist;
        id_nxt   = prev_ent.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    id_r   <= id_nxt;
  end

  assign ent.vld     = vld_r;
  assign ent.sq_dist = dist_r;
  assign ent.id      = id_r;

endmodule

// ===== hw/rtl/nearest_k_point_selector.sv =====
// Top level of the nearest-k point selector: config registers, distance
// pipeline, insertion chain of cells and readout sequencer.
// Depends on nkps_pkg, nkps_dist and nkps_cell.
//
// Usage: write ref_x/ref_y/ref_z through cfg_we/cfg_index/cfg_wdata while
// idle. Present a candidate point on the in_ ports with start high; it is
// taken at a clock edge where busy is low. Candidates without in_final_point
// stream at one per cycle while busy is low and produce nothing. A candidate
// with in_final_point is inserted like the others, then the list is read out
// as DEPTH = min(KEEP_COUNT, 8) slots on consecutive cycles, nearest first,
// each marked by out_strobe for one cycle; out_last_slot flags the final
// slot and unused slots carry zero with out_slot_valid low. The first slot
// appears once the final candidate has passed the 3-stage distance pipeline
// and the insertion step; busy stays high from the edge after it is taken
// until the last slot has gone. Readout empties the list. The receiver cannot
// stall. Reset clears the list, the reference point and the pipeline.
module nearest_k_point_selector #(
  parameter int KEEP_COUNT = nkps_pkg::KEEP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [nkps_pkg::ID_W-1:0]           in_point_id,
  input  logic signed [nkps_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [nkps_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [nkps_pkg::COORD_W-1:0] in_point_z,
  input  logic                                in_final_point,
  output logic                                out_strobe,
  output logic [nkps_pkg::SLOT_W-1:0]         out_slot_index,
  output logic                                out_slot_valid,
  output logic [nkps_pkg::ID_W-1:0]           out_selected_id,
  output logic [nkps_pkg::DIST_W-1:0]         out_selected_distance,
  output logic                                out_last_slot,
  input  logic                                cfg_we,
  input  logic [nkps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nkps_pkg::COORD_W-1:0]        cfg_wdata
);
  import nkps_pkg::*;

  localparam int DEPTH = (KEEP_COUNT > SLOT_MAX) ? SLOT_MAX : KEEP_COUNT;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(DEPTH - 1);

  ref_pt_t           ref_r;
  cand_t             cand;
  logic              fin_pending;
  logic              acc;
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  cell_ctrl_t        ctrl;
  entry_t            ent  [DEPTH];
  logic              keep [DEPTH];
  logic [DEPTH-1:0]  vld_vec;

  assign acc = start & ~busy;

  // Decode configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_X: ref_r.x <= cfg_wdata;
        REG_REF_Y: ref_r.y <= cfg_wdata;
        REG_REF_Z: ref_r.z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  nkps_dist u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .point_id    (in_point_id),
    .point_x     (in_point_x),
    .point_y     (in_point_y),
    .point_z     (in_point_z),
    .final_point (in_final_point),
    .ref_pt      (ref_r),
    .cand        (cand),
    .fin_pending (fin_pending)
  );

  // Readout sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl.ins  = 1'b0;
    ctrl.drn  = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        ctrl.ins = cand.vld;
        cnt_nxt  = '0;
        if (cand.vld && cand.fin) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ctrl.drn = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_COLLECT;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  // Insertion chain: each cell sees its neighbours on both sides
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t pe, ne;
    logic   pk;
    if (i == 0) begin : g_head
      assign pe = ENTRY_EMPTY;
      assign pk = 1'b1;
    end else begin : g_body
      assign pe = ent[i-1];
      assign pk = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign ne = ENTRY_EMPTY;
    end else begin : g_inner
      assign ne = ent[i+1];
    end
    nkps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cand_dist (cand.sq_dist),
      .cand_id   (cand.id),
      .prev_ent  (pe),
      .prev_keep (pk),
      .next_ent  (ne),
      .ent       (ent[i]),
      .keep      (keep[i])
    );
    assign vld_vec[i] = ent[i].vld;
  end

  // Present the head cell during readout
  assign busy                  = (state_r == ST_DRAIN) | fin_pending;
  assign out_strobe            = (state_r == ST_DRAIN);
  assign out_slot_index        = cnt_r;
  assign out_slot_valid        = ent[0].vld;
  assign out_selected_id       = ent[0].vld ? ent[0].id : '0;
  assign out_selected_distance = ent[0].vld ? ent[0].sq_dist : '0;
  assign out_last_slot         = out_strobe && (cnt_r == LAST_IDX);

`ifndef SYNTHESIS
  // Kept entries always fill the chain from the head
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_vec & (vld_vec + 1'b1)) == '0)
    else $error("kept entries not contiguous from head");

  // A final candidate produces slot 0 after the distance pipeline and the insertion step
  a_first_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_final_point) |-> ##4 (out_strobe && out_slot_index == '0))
    else $error("readout did not start on time");

  // Slots run back to back with rising rank
  a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_slot) |=>
      (out_strobe && out_slot_index == $past(out_slot_index) + 1'b1))
    else $error("readout slot sequence broken");

  // The list is empty once readout ends
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_slot |=> (vld_vec == '0 && !out_strobe))
    else $error("list not cleared after readout");
`endif

endmodule
